// ----- src/dual_motor_pwm_ramp_macros.svh -----
// Assertion macros shared by the motor drive RTL.
// Every macro checks on the rising edge of clk_i and is off while rst_ni is low.
`ifndef DUAL_MOTOR_PWM_RAMP_MACROS_SVH
`define DUAL_MOTOR_PWM_RAMP_MACROS_SVH
`ifndef NO_ASSERTIONS
// The condition holds at every clock edge.
`define DMPR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("dmpr assertion failed");
// The consequent holds in the same cycle as the antecedent.
`define DMPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmpr implication failed");
// The consequent holds in the cycle after the antecedent.
`define DMPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmpr next-cycle check failed");
`else
`define DMPR_ASSERT(lbl, cond)
`define DMPR_ASSERT_IMP(lbl, ante, cons)
`define DMPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/dmpr_pkg.sv -----
// Shared constants, codes and types of the dual motor PWM ramp block.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package dmpr_pkg;

  // Fixed scaling of the drive.
  localparam int unsigned PWM_TOP       = 999;
  localparam int unsigned SPEED_LIMIT   = 400;
  localparam int unsigned REVERSE_FLOOR = 100;

  // Field widths.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned SPD_W = 16;
  localparam int unsigned TGT_W = 16;
  localparam int unsigned DLY_W = 16;
  localparam int unsigned CMP_W = 10;
  localparam int unsigned MAG_W = $clog2(SPEED_LIMIT + 1);

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_CHANGE = 2'd1,
    OP_TICK   = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  // Ramp phase of one side.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SLOW  = 2'd1,
    PH_CLIMB = 2'd2
  } phase_e;

  // Decoded command word held in the input register.
  typedef struct packed {
    op_e              op;
    logic             side;
    logic             set_backward;
    logic [CMP_W-1:0] set_compare;
    logic             goal_backward;
    logic [CMP_W-1:0] goal_compare;
    logic [DLY_W-1:0] reload;
  } cmd_t;

  // Visible state of one side.
  typedef struct packed {
    logic [CMP_W-1:0] compare;
    logic             backward;
    logic             ramping;
  } side_status_t;

  // Drive state that one ramp step changes.
  typedef struct packed {
    logic [CMP_W-1:0] compare;
    logic             backward;
    phase_e           phase;
  } ramp_t;

endpackage

`default_nettype wire

// ----- src/dual_motor_pwm_ramp.sv -----
// Dual motor PWM drive with slew-limited ramps on each side.
// A result word is valid after its input word has passed the input register and then
// the side state registers. Throughput: one word per cycle unless the output stalls;
// the two registers form two stages, and the output stall holds both.
// Reset: both compare values 0, directions forward, ramps idle, step delay 1.
`default_nettype none

module dual_motor_pwm_ramp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [dmpr_pkg::OP_W-1:0]    operation_i,
  input  wire logic                        side_i,
  input  wire logic signed [dmpr_pkg::SPD_W-1:0] signed_speed_i,
  input  wire logic                        target_backward_i,
  input  wire logic [dmpr_pkg::TGT_W-1:0]   target_compare_i,
  input  wire logic [dmpr_pkg::DLY_W-1:0]   step_delay_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [dmpr_pkg::CMP_W-1:0]        left_compare_o,
  output logic                             left_backward_o,
  output logic [dmpr_pkg::CMP_W-1:0]        right_compare_o,
  output logic                             right_backward_o,
  output logic                             left_ramping_o,
  output logic                             right_ramping_o
);

  import dmpr_pkg::*;
`include "dual_motor_pwm_ramp_macros.svh"

  logic         s1_v_q, s1_v_d;
  logic         out_v_q, out_v_d;
  logic         load;
  logic         advance;
  cmd_t         cmd;
  side_status_t left_st, right_st;

  // Handshake: the input register moves on whenever the result slot is free.
  assign advance    = s1_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = s1_v_q && out_v_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;
  assign s1_v_d     = load || (s1_v_q && !advance);
  assign out_v_d    = advance || (out_v_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Input register with speed scaling.
  dmpr_decode u_decode (
    .clk_i             (clk_i),
    .load_i            (load),
    .operation_i       (operation_i),
    .side_i            (side_i),
    .signed_speed_i    (signed_speed_i),
    .target_backward_i (target_backward_i),
    .target_compare_i  (target_compare_i),
    .step_delay_i      (step_delay_i),
    .cmd_o             (cmd)
  );

  // Left and right motor state.
  dmpr_side u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .hit_i    (!cmd.side),
    .cmd_i    (cmd),
    .status_o (left_st)
  );

  dmpr_side u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .hit_i    (cmd.side),
    .cmd_i    (cmd),
    .status_o (right_st)
  );

  // Result word straight from the side state.
  assign out_valid_o      = out_v_q;
  assign left_compare_o   = left_st.compare;
  assign left_backward_o  = left_st.backward;
  assign left_ramping_o   = left_st.ramping;
  assign right_compare_o  = right_st.compare;
  assign right_backward_o = right_st.backward;
  assign right_ramping_o  = right_st.ramping;

  // The input side stalls only when both stages are full and blocked.
  `DMPR_ASSERT_IMP(a_stall_full, in_stall_o, s1_v_q && out_v_q)
  // A word that leaves the input register shows up as a result.
  `DMPR_ASSERT_NXT(a_adv_out, advance, out_v_q)
  // While a result waits, the side state does not move.
  `DMPR_ASSERT_NXT(a_hold, out_v_q && out_stall_i,
                   $stable(left_st) && $stable(right_st))

endmodule

`default_nettype wire

// ----- src/dmpr_decode.sv -----
// Input register of the motor drive: clamps and scales the signed speed,
// saturates the target and fixes a zero delay. Depends on dmpr_pkg.
`default_nettype none

module dmpr_decode (
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire logic [dmpr_pkg::OP_W-1:0]  operation_i,
  input  wire logic                      side_i,
  input  wire logic signed [dmpr_pkg::SPD_W-1:0] signed_speed_i,
  input  wire logic                      target_backward_i,
  input  wire logic [dmpr_pkg::TGT_W-1:0] target_compare_i,
  input  wire logic [dmpr_pkg::DLY_W-1:0] step_delay_i,
  output dmpr_pkg::cmd_t                 cmd_o
);

  import dmpr_pkg::*;

  // Reciprocal of the speed limit, scaled by PWM_TOP, in FRAC_W fraction bits.
  localparam int unsigned FRAC_W  = 16;
  localparam longint unsigned RECIP_L =
    (longint'(PWM_TOP) << FRAC_W) / longint'(SPEED_LIMIT);
  localparam int unsigned RECIP_W = $clog2(RECIP_L + 1);
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;
  localparam int unsigned NUM_W   = MAG_W + $clog2(PWM_TOP + 1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic signed [SPD_W:0] LIM = (SPD_W+1)'(SPEED_LIMIT);

  logic signed [SPD_W:0] clamped;
  logic signed [SPD_W:0] abs_speed;
  logic [MAG_W-1:0]      mag;
  logic [PROD_W-1:0]     prod;
  logic [CMP_W-1:0]      est;
  logic [NUM_W-1:0]      rem;
  logic [CMP_W-1:0]      scaled;
  cmd_t                  cmd_d, cmd_q;

  // Clamp the speed to the limit and take its magnitude.
  always_comb begin
    if (signed_speed_i > LIM) begin
      clamped = LIM;
    end else if (signed_speed_i < -LIM) begin
      clamped = -LIM;
    end else begin
      clamped = (SPD_W+1)'(signed_speed_i);
    end
    abs_speed = clamped[SPD_W] ? -clamped : clamped;
    mag       = abs_speed[MAG_W-1:0];
  end

  // Scale by PWM_TOP / SPEED_LIMIT: reciprocal estimate, then one correction.
  always_comb begin
    prod = PROD_W'(mag) * PROD_W'(RECIP);
    est  = prod[FRAC_W +: CMP_W];
    rem  = NUM_W'(mag) * NUM_W'(PWM_TOP) - NUM_W'(est) * NUM_W'(SPEED_LIMIT);
    scaled = est + CMP_W'(rem >= NUM_W'(SPEED_LIMIT));
  end

  // Assemble the command word.
  always_comb begin
    cmd_d.op            = op_e'(operation_i);
    cmd_d.side          = side_i;
    cmd_d.set_backward  = clamped[SPD_W];
    cmd_d.set_compare   = scaled;
    cmd_d.goal_backward = target_backward_i;
    cmd_d.goal_compare  = (target_compare_i > TGT_W'(PWM_TOP)) ? CMP_W'(PWM_TOP)
                                                              : target_compare_i[CMP_W-1:0];
    cmd_d.reload        = (step_delay_i == '0) ? DLY_W'(1) : step_delay_i;
  end

  // Payload register; its valid bit lives in the top level.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule

`default_nettype wire

// ----- src/dmpr_side.sv -----
// State and update logic of one motor side: direct set, paced ramp with
// slow-down before reversal, and stop. Depends on dmpr_pkg and the macros header.
`default_nettype none

module dmpr_side (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire logic           hit_i,
  input  dmpr_pkg::cmd_t      cmd_i,
  output dmpr_pkg::side_status_t status_o
);

  import dmpr_pkg::*;
`include "dual_motor_pwm_ramp_macros.svh"

  localparam logic [CMP_W-1:0] FLOOR = CMP_W'(REVERSE_FLOOR);

  ramp_t            now_q, now_d;
  logic [CMP_W-1:0] goal_q, goal_d;
  logic             goal_dir_q, goal_dir_d;
  logic [DLY_W-1:0] reload_q, reload_d;
  logic [DLY_W-1:0] cd_q, cd_d;
  logic [DLY_W-1:0] cd_dec;
  ramp_t            start;
  ramp_t            stepped;

  // One ramp step: slow down toward the floor, then reverse and climb.
  function automatic ramp_t ramp_step(ramp_t r, logic [CMP_W-1:0] goal, logic goal_dir);
    ramp_t            n;
    logic [CMP_W-1:0] base;
    logic             dir;
    n = r;
    if (r.phase == PH_SLOW && r.compare > FLOOR) begin
      n.compare = r.compare - 1'b1;
    end else if (r.phase == PH_SLOW || r.phase == PH_CLIMB) begin
      base = (r.phase == PH_SLOW) ? '0 : r.compare;
      dir  = (r.phase == PH_SLOW) ? goal_dir : r.backward;
      if (base < goal) begin
        n.compare = base + 1'b1;
      end else if (base > goal) begin
        n.compare = base - 1'b1;
      end else begin
        n.compare = base;
      end
      n.backward = dir;
      n.phase    = (n.compare == goal && dir == goal_dir) ? PH_IDLE : PH_CLIMB;
    end
    return n;
  endfunction

  // Step inputs for a new ramp command and for a tick.
  always_comb begin
    start          = now_q;
    if (now_q.backward != cmd_i.goal_backward) begin
      start.phase = PH_SLOW;
    end else if (now_q.compare != cmd_i.goal_compare) begin
      start.phase = PH_CLIMB;
    end else begin
      start.phase = PH_IDLE;
    end
    cd_dec = cd_q - DLY_W'(cd_q != '0);
    if (cmd_i.op == OP_CHANGE) begin
      stepped = ramp_step(start, cmd_i.goal_compare, cmd_i.goal_backward);
    end else begin
      stepped = ramp_step(now_q, goal_q, goal_dir_q);
    end
  end

  // Next state for the command at the head of the pipeline.
  always_comb begin
    now_d      = now_q;
    goal_d     = goal_q;
    goal_dir_d = goal_dir_q;
    reload_d   = reload_q;
    cd_d       = cd_q;
    if (fire_i) begin
      unique case (cmd_i.op)
        OP_SET: begin
          if (hit_i) begin
            now_d.compare  = cmd_i.set_compare;
            now_d.backward = cmd_i.set_backward;
            now_d.phase    = PH_IDLE;
            goal_d         = cmd_i.set_compare;
            goal_dir_d     = cmd_i.set_backward;
            cd_d           = '0;
          end
        end
        OP_CHANGE: begin
          if (hit_i) begin
            goal_d     = cmd_i.goal_compare;
            goal_dir_d = cmd_i.goal_backward;
            reload_d   = cmd_i.reload;
            now_d      = stepped;
            cd_d       = (stepped.phase != PH_IDLE) ? cmd_i.reload : '0;
          end
        end
        OP_TICK: begin
          if (now_q.phase != PH_IDLE) begin
            if (cd_dec == '0) begin
              now_d = stepped;
              cd_d  = (stepped.phase != PH_IDLE) ? reload_q : '0;
            end else begin
              cd_d = cd_dec;
            end
          end
        end
        OP_STOP: begin
          now_d.compare = '0;
          now_d.phase   = PH_IDLE;
          goal_d        = '0;
          goal_dir_d    = now_q.backward;
          cd_d          = '0;
        end
        default: begin
          now_d = now_q;
        end
      endcase
    end
  end

  // State registers; they double as this side's result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q.compare  <= '0;
      now_q.backward <= 1'b0;
      now_q.phase    <= PH_IDLE;
      goal_q         <= '0;
      goal_dir_q     <= 1'b0;
      reload_q       <= DLY_W'(1);
      cd_q           <= '0;
    end else begin
      now_q      <= now_d;
      goal_q     <= goal_d;
      goal_dir_q <= goal_dir_d;
      reload_q   <= reload_d;
      cd_q       <= cd_d;
    end
  end

  assign status_o.compare  = now_q.compare;
  assign status_o.backward = now_q.backward;
  assign status_o.ramping  = (now_q.phase != PH_IDLE);

  // The compare value never leaves the PWM range.
  `DMPR_ASSERT(a_cmp_range, now_q.compare <= CMP_W'(PWM_TOP))
  // An idle side keeps no pending countdown.
  `DMPR_ASSERT_IMP(a_idle_cd, now_q.phase == PH_IDLE, cd_q == '0)
  // A stop leaves the side at zero with no ramp.
  `DMPR_ASSERT_NXT(a_stop, fire_i && cmd_i.op == OP_STOP,
                   now_q.compare == '0 && now_q.phase == PH_IDLE)

endmodule

`default_nettype wire

// ----- dv/dual_motor_pwm_ramp_tb.sv -----
// Testbench for the dual motor PWM ramp block: directed and random command words with
// random idling on both channels, checked word by word against an in-bench drive model.
// Depends on dmpr_pkg and the dual_motor_pwm_ramp RTL.
`default_nettype none

module dual_motor_pwm_ramp_tb;
  import dmpr_pkg::*;

  localparam int CHOKE_CYCLES = 60;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;

  // Status of both sides as one result word.
  typedef struct packed {
    side_status_t left;
    side_status_t right;
  } drive_word_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         operation_i;
  logic                    side_i;
  logic signed [SPD_W-1:0] signed_speed_i;
  logic                    target_backward_i;
  logic [TGT_W-1:0]        target_compare_i;
  logic [DLY_W-1:0]        step_delay_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [CMP_W-1:0]        left_compare_o;
  logic                    left_backward_o;
  logic [CMP_W-1:0]        right_compare_o;
  logic                    right_backward_o;
  logic                    left_ramping_o;
  logic                    right_ramping_o;

  // Drive model state, one entry per side.
  logic [CMP_W-1:0] duty_now [2];
  logic             back_now [2];
  logic [CMP_W-1:0] duty_goal [2];
  logic             back_goal [2];
  logic [DLY_W-1:0] step_reload [2];
  logic [DLY_W-1:0] step_timer [2];
  phase_e           ramp_state [2];

  drive_word_t expected_status [$];
  int          fails;
  int          quiet_cycles;
  logic        idle_on;
  logic        choke_req;

  dual_motor_pwm_ramp dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .side_i            (side_i),
    .signed_speed_i    (signed_speed_i),
    .target_backward_i (target_backward_i),
    .target_compare_i  (target_compare_i),
    .step_delay_i      (step_delay_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .left_compare_o    (left_compare_o),
    .left_backward_o   (left_backward_o),
    .right_compare_o   (right_compare_o),
    .right_backward_o  (right_backward_o),
    .left_ramping_o    (left_ramping_o),
    .right_ramping_o   (right_ramping_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Gap length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 25));
  endfunction

  // One ramp step of one side: slow down to the floor, flip, then climb toward the goal.
  function automatic void step_side(int s);
    if (ramp_state[s] == PH_SLOW) begin
      if (duty_now[s] > REVERSE_FLOOR) begin
        duty_now[s] = duty_now[s] - 1'b1;
        return;
      end
      duty_now[s] = '0;
      back_now[s] = back_goal[s];
      ramp_state[s] = PH_CLIMB;
    end
    if (ramp_state[s] == PH_CLIMB) begin
      if (duty_now[s] < duty_goal[s]) begin
        duty_now[s] = duty_now[s] + 1'b1;
      end else if (duty_now[s] > duty_goal[s]) begin
        duty_now[s] = duty_now[s] - 1'b1;
      end
      if (duty_now[s] == duty_goal[s] && back_now[s] == back_goal[s]) begin
        ramp_state[s] = PH_IDLE;
        step_timer[s] = '0;
      end
    end
  endfunction

  // Applies one command word to the drive model and returns the status after it.
  function automatic drive_word_t apply_motor_word(op_e op, logic s,
                                                   logic signed [SPD_W-1:0] speed,
                                                   logic tback, logic [TGT_W-1:0] tcmp,
                                                   logic [DLY_W-1:0] dly);
    int          sp;
    int          lim;
    int          k;
    int unsigned goal;
    drive_word_t w;
    lim = int'(SPEED_LIMIT);
    case (op)
      OP_SET: begin
        sp = speed;
        if (sp > lim) sp = lim;
        if (sp < -lim) sp = -lim;
        back_now[s] = (sp < 0);
        if (sp < 0) sp = -sp;
        duty_now[s] = CMP_W'(sp * int'(PWM_TOP) / lim);
        duty_goal[s] = duty_now[s];
        back_goal[s] = back_now[s];
        ramp_state[s] = PH_IDLE;
        step_timer[s] = '0;
      end
      OP_CHANGE: begin
        goal = (tcmp > PWM_TOP) ? PWM_TOP : int'(tcmp);
        duty_goal[s] = CMP_W'(goal);
        back_goal[s] = tback;
        step_reload[s] = (dly == '0) ? DLY_W'(1) : dly;
        if (back_now[s] != tback) begin
          ramp_state[s] = PH_SLOW;
        end else if (duty_now[s] != duty_goal[s]) begin
          ramp_state[s] = PH_CLIMB;
        end else begin
          ramp_state[s] = PH_IDLE;
        end
        step_timer[s] = '0;
        if (ramp_state[s] != PH_IDLE) begin
          step_side(int'(s));
          if (ramp_state[s] != PH_IDLE) step_timer[s] = step_reload[s];
        end
      end
      OP_TICK: begin
        for (k = 0; k < 2; k++) begin
          if (ramp_state[k] != PH_IDLE) begin
            if (step_timer[k] != '0) step_timer[k] = step_timer[k] - 1'b1;
            if (step_timer[k] == '0) begin
              step_side(k);
              if (ramp_state[k] != PH_IDLE) step_timer[k] = step_reload[k];
            end
          end
        end
      end
      default: begin
        for (k = 0; k < 2; k++) begin
          duty_now[k] = '0;
          duty_goal[k] = '0;
          back_goal[k] = back_now[k];
          ramp_state[k] = PH_IDLE;
          step_timer[k] = '0;
        end
      end
    endcase
    w.left.compare  = duty_now[0];
    w.left.backward = back_now[0];
    w.left.ramping  = (ramp_state[0] != PH_IDLE);
    w.right.compare  = duty_now[1];
    w.right.backward = back_now[1];
    w.right.ramping  = (ramp_state[1] != PH_IDLE);
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  // Predict on every accepted command word, then compare every accepted result word.
  always @(posedge clk_i) begin : status_check
    drive_word_t got;
    drive_word_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_status.push_back(apply_motor_word(op_e'(operation_i), side_i,
                                                   signed_speed_i, target_backward_i,
                                                   target_compare_i, step_delay_i));
      end
      if (out_valid_o && !out_stall_i) begin
        got.left  = '{left_compare_o, left_backward_o, left_ramping_o};
        got.right = '{right_compare_o, right_backward_o, right_ramping_o};
        if (expected_status.size() == 0) begin
          $display("%0t: result word with none expected, expected none, actual %h",
                   $time, got);
          fails++;
        end else begin
          want = expected_status.pop_front();
          check_field("left_compare", want.left.compare, got.left.compare);
          check_field("left_backward", want.left.backward, got.left.backward);
          check_field("right_compare", want.right.compare, got.right.compare);
          check_field("right_backward", want.right.backward, got.right.backward);
          check_field("left_ramping", want.left.ramping, got.left.ramping);
          check_field("right_ramping", want.right.ramping, got.right.ramping);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Output stall: random gaps, or one long hold-off when requested.
  initial begin : result_stall
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (choke_req) begin
        out_stall_i <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk_i);
        choke_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        n = idle_on ? pick_gap() : 0;
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one command word after an optional gap and waits until it is taken.
  task automatic send_word(op_e op, logic s, logic signed [SPD_W-1:0] speed, logic tback,
                           logic [TGT_W-1:0] tcmp, logic [DLY_W-1:0] dly);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    side_i            <= s;
    signed_speed_i    <= speed;
    target_backward_i <= tback;
    target_compare_i  <= tcmp;
    step_delay_i      <= dly;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random command word: mostly ticks and ramps toward nearby targets.
  task automatic send_random_word();
    int                      r;
    op_e                     op;
    logic signed [SPD_W-1:0] sp;
    logic [TGT_W-1:0]        tc;
    logic [DLY_W-1:0]        dl;
    r = int'($urandom_range(0, 99));
    if (r < 45) op = OP_TICK;
    else if (r < 72) op = OP_CHANGE;
    else if (r < 95) op = OP_SET;
    else op = OP_STOP;
    r = int'($urandom_range(0, 9));
    if (r < 5) sp = SPD_W'(int'($urandom_range(0, 120)) - 60);
    else if (r < 7) sp = SPD_W'(int'($urandom_range(360, 440)) * ($urandom_range(0, 1) ? -1 : 1));
    else sp = SPD_W'($urandom);
    r = int'($urandom_range(0, 9));
    if (r < 4) tc = TGT_W'($urandom_range(0, 130));
    else if (r < 7) tc = TGT_W'($urandom_range(0, PWM_TOP));
    else if (r < 8) tc = TGT_W'($urandom_range(PWM_TOP + 1, PWM_TOP + 30));
    else tc = TGT_W'($urandom);
    r = int'($urandom_range(0, 9));
    if (r < 6) dl = DLY_W'($urandom_range(0, 2));
    else if (r < 8) dl = DLY_W'($urandom_range(3, 6));
    else if (r < 9) dl = DLY_W'($urandom_range(7, 40));
    else dl = DLY_W'($urandom);
    send_word(op, 1'($urandom_range(0, 1)), sp, 1'($urandom_range(0, 1)), tc, dl);
  endtask

  // Signed sets at the speed extremes and around the clamp.
  task automatic test_set_extremes();
    send_word(OP_SET, 1'b0, 16'sd0, 1'b0, '0, '0);
    send_word(OP_SET, 1'b0, 16'sd1, 1'b0, '0, '0);
    send_word(OP_SET, 1'b0, -16'sd1, 1'b0, '0, '0);
    send_word(OP_SET, 1'b1, 16'sd400, 1'b0, '0, '0);
    send_word(OP_SET, 1'b1, -16'sd400, 1'b0, '0, '0);
    send_word(OP_SET, 1'b0, 16'sh7fff, 1'b1, 16'hffff, 16'hffff);
    send_word(OP_SET, 1'b1, 16'sh8000, 1'b1, 16'hffff, 16'hffff);
    send_word(OP_SET, 1'b0, 16'sd401, 1'b0, '0, '0);
  endtask

  // Stop, idle ticks, reversal below and above the floor, cancels and saturation.
  task automatic test_ramp_cases();
    int n;
    send_word(OP_STOP, 1'b0, '0, 1'b0, '0, '0);
    send_word(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    // Change to the present value and direction takes no step.
    send_word(OP_CHANGE, 1'b1, '0, 1'b1, 16'd0, 16'd3);
    // Reversal starting below the floor jumps to zero at once.
    send_word(OP_SET, 1'b0, 16'sd40, 1'b0, '0, '0);
    send_word(OP_CHANGE, 1'b0, '0, 1'b1, 16'd3, 16'd1);
    for (n = 0; n < 2; n++) send_word(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    // Reversal starting above the floor slows down first.
    send_word(OP_SET, 1'b1, 16'sd41, 1'b0, '0, '0);
    send_word(OP_CHANGE, 1'b1, '0, 1'b1, 16'd2, 16'd2);
    for (n = 0; n < 4; n++) send_word(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    // A signed set cancels the active ramp.
    send_word(OP_SET, 1'b1, -16'sd5, 1'b0, '0, '0);
    // Saturated target with the longest delay, then a stop mid-ramp.
    send_word(OP_CHANGE, 1'b0, '0, 1'b0, 16'hffff, 16'hffff);
    send_word(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    send_word(OP_STOP, 1'b1, '0, 1'b0, '0, '0);
    // Zero delay behaves as one tick per step.
    send_word(OP_CHANGE, 1'b1, '0, 1'b0, 16'd5, 16'd0);
    send_word(OP_TICK, 1'b0, '0, 1'b0, '0, '0);
  endtask

  // Long output hold-off while words keep coming, so the block backs up its input.
  task automatic test_output_backpressure();
    int n;
    idle_on = 1'b0;
    choke_req = 1'b1;
    for (n = 0; n < 40; n++) send_random_word();
    idle_on = 1'b1;
  endtask

  // Random traffic in chunks, some of them with no idling on either side.
  task automatic test_random_traffic();
    int chunk;
    for (chunk = 0; chunk < 7; chunk++) begin
      idle_on = (chunk % 3 != 2);
      repeat (100) send_random_word();
    end
    idle_on = 1'b1;
  endtask

  initial begin : main
    int k;
    fails = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    choke_req = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_TICK;
    side_i = 1'b0;
    signed_speed_i = '0;
    target_backward_i = 1'b0;
    target_compare_i = '0;
    step_delay_i = '0;
    for (k = 0; k < 2; k++) begin
      duty_now[k] = '0;
      back_now[k] = 1'b0;
      duty_goal[k] = '0;
      back_goal[k] = 1'b0;
      step_reload[k] = DLY_W'(1);
      step_timer[k] = '0;
      ramp_state[k] = PH_IDLE;
    end
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_set_extremes();
    test_ramp_cases();
    test_output_backpressure();
    test_random_traffic();
    in_valid_i <= 1'b0;

    // Let the last accepted word be queued, then drain all outstanding
    // result words and allow the pipeline to settle.
    @(posedge clk_i);
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
